// ===== rtl/core/z85_codec_with_position_rotation_defines.svh =====
// assertion helpers used by the codec back end
`ifndef Z85_CODEC_WITH_POSITION_ROTATION_DEFINES_SVH
`define Z85_CODEC_WITH_POSITION_ROTATION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define Z85_ASSERT_NOW(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// next-cycle implication, checked outside reset
`define Z85_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/core/z85_pkg.sv =====
`default_nettype none

package z85_pkg;

  // digit width and alphabet size
  localparam int DIG_W      = 7;
  localparam int NUM_DIGITS = 5;
  localparam logic [DIG_W-1:0] SYMBOLS = 7'd85;
  localparam logic [DIG_W-1:0] LAST_DIGIT = 7'd4;

  // one classified item as it travels from front to back
  typedef struct packed {
    logic                                sos;
    logic                                dec;
    logic [DIG_W-1:0]                    cdig;
    logic                                cbad;
    logic [NUM_DIGITS-1:0][DIG_W-1:0]    dig;
  } z85_entry_t;

  // head of the queue as seen by the back end
  typedef struct packed {
    logic       valid;
    z85_entry_t entry;
  } z85_head_t;

endpackage

`default_nettype wire

// ===== rtl/core/z85_if.sv =====
`default_nettype none

// input channel: one word or one character per transfer
interface z85_in_if;
  logic        valid;
  logic        ready;
  logic        start_of_stream;
  logic [31:0] data_word;
  logic [7:0]  in_char;

  modport source (output valid, output start_of_stream, output data_word, output in_char,
                  input ready);
  modport sink (input valid, input start_of_stream, input data_word, input in_char,
                output ready);
endinterface

// output channel: one character or one word per transfer
interface z85_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic [31:0] out_word;
  logic        last;
  logic        bad_char;

  modport source (output valid, output out_char, output out_word, output last,
                  output bad_char, input ready);
  modport sink (input valid, input out_char, input out_word, input last, input bad_char,
                output ready);
endinterface

`default_nettype wire

// ===== rtl/core/z85_front.sv =====
`default_nettype none

module z85_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             decode_mode,
  z85_in_if.sink                item,
  input  wire logic             q_full,
  output logic                  q_push,
  output z85_pkg::z85_entry_t   q_entry
);
  import z85_pkg::*;

  localparam int STAGES = NUM_DIGITS - 1;
  localparam logic [31:0] RECIP = 32'hC0C0C0C1;
  localparam int RECIP_SHIFT = 38;

  typedef struct packed {
    logic                             sos;
    logic                             dec;
    logic [DIG_W-1:0]                 cdig;
    logic                             cbad;
    logic [31:0]                      quo;
    logic [DIG_W-1:0]                 low;
    logic [NUM_DIGITS-1:0][DIG_W-1:0] dig;
  } stage_t;

  // exact x / 85 for any 32-bit x by reciprocal multiply
  function automatic logic [31:0] div85(input logic [31:0] x);
    logic [63:0] prod;
    prod = 64'(x) * 64'(RECIP);
    return 32'(prod[63:RECIP_SHIFT]);
  endfunction

  // remainder from low bits of dividend and quotient, known to be below 85
  function automatic logic [DIG_W-1:0] rem85(input logic [DIG_W-1:0] low,
                                             input logic [DIG_W-1:0] q);
    logic [DIG_W-1:0] qm;
    qm = DIG_W'(q * SYMBOLS);
    return low - qm;
  endfunction

  // character to digit, with a flag for characters outside the alphabet
  function automatic logic [DIG_W:0] char_digit(input logic [7:0] c);
    logic [DIG_W:0] r;
    r = {1'b0, DIG_W'(0)};
    if (c >= "0" && c <= "9") r = {1'b0, DIG_W'(c - 8'd48)};
    else if (c >= "a" && c <= "z") r = {1'b0, DIG_W'(c - 8'd87)};
    else if (c >= "A" && c <= "Z") r = {1'b0, DIG_W'(c - 8'd29)};
    else begin
      unique case (c)
        ".": r = {1'b0, 7'd62};
        "-": r = {1'b0, 7'd63};
        ":": r = {1'b0, 7'd64};
        "+": r = {1'b0, 7'd65};
        "=": r = {1'b0, 7'd66};
        "^": r = {1'b0, 7'd67};
        "!": r = {1'b0, 7'd68};
        "/": r = {1'b0, 7'd69};
        "*": r = {1'b0, 7'd70};
        "?": r = {1'b0, 7'd71};
        "&": r = {1'b0, 7'd72};
        "<": r = {1'b0, 7'd73};
        ">": r = {1'b0, 7'd74};
        "(": r = {1'b0, 7'd75};
        ")": r = {1'b0, 7'd76};
        "[": r = {1'b0, 7'd77};
        "]": r = {1'b0, 7'd78};
        "{": r = {1'b0, 7'd79};
        "}": r = {1'b0, 7'd80};
        "@": r = {1'b0, 7'd81};
        "%": r = {1'b0, 7'd82};
        "$": r = {1'b0, 7'd83};
        "#": r = {1'b0, 7'd84};
        default: r = {1'b1, DIG_W'(0)};
      endcase
    end
    return r;
  endfunction

  stage_t st     [STAGES];
  stage_t st_nxt [STAGES];
  logic   vld    [STAGES];
  logic   rdy    [STAGES];
  logic [DIG_W:0] cd;

  // elastic ready chain, last stage waits on queue space
  assign rdy[STAGES-1] = !vld[STAGES-1] || !q_full;
  genvar k;
  generate
    for (k = 0; k < STAGES - 1; k++) begin : g_rdy
      assign rdy[k] = !vld[k] || rdy[k+1];
    end
  endgenerate
  assign item.ready = rdy[0];

  // first stage: classify and start the digit split
  always_comb begin
    cd = char_digit(item.in_char);
    st_nxt[0]      = '0;
    st_nxt[0].sos  = item.start_of_stream;
    st_nxt[0].dec  = decode_mode;
    st_nxt[0].cdig = cd[DIG_W-1:0];
    st_nxt[0].cbad = cd[DIG_W];
    st_nxt[0].quo  = div85(item.data_word);
    st_nxt[0].low  = item.data_word[DIG_W-1:0];
  end

  // later stages: one division by 85 each, least significant digit first
  generate
    for (k = 1; k < STAGES; k++) begin : g_div
      always_comb begin
        st_nxt[k]     = st[k-1];
        st_nxt[k].dig[NUM_DIGITS-k] = rem85(st[k-1].low, st[k-1].quo[DIG_W-1:0]);
        st_nxt[k].quo = div85(st[k-1].quo);
        st_nxt[k].low = st[k-1].quo[DIG_W-1:0];
      end
    end
  endgenerate

  // stage registers
  generate
    for (k = 0; k < STAGES; k++) begin : g_stage
      always_ff @(posedge clk) begin
        if (rst) begin
          vld[k] <= 1'b0;
        end else if (rdy[k]) begin
          vld[k] <= (k == 0) ? item.valid : vld[(k == 0) ? 0 : k - 1];
        end
        if (rdy[k]) begin
          st[k] <= st_nxt[k];
        end
      end
    end
  endgenerate

  // last digit pair falls out of the final stage
  always_comb begin
    q_entry        = '0;
    q_entry.sos    = st[STAGES-1].sos;
    q_entry.dec    = st[STAGES-1].dec;
    q_entry.cdig   = st[STAGES-1].cdig;
    q_entry.cbad   = st[STAGES-1].cbad;
    q_entry.dig    = st[STAGES-1].dig;
    q_entry.dig[1] = rem85(st[STAGES-1].low, st[STAGES-1].quo[DIG_W-1:0]);
    q_entry.dig[0] = st[STAGES-1].quo[DIG_W-1:0];
  end
  assign q_push = vld[STAGES-1] && !q_full;

endmodule

`default_nettype wire

// ===== rtl/core/z85_fifo.sv =====
`default_nettype none

module z85_fifo #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  input  wire z85_pkg::z85_entry_t  push_entry,
  output logic                      full,
  input  wire logic                 pop,
  output z85_pkg::z85_head_t        head
);
  import z85_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

  z85_entry_t       mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign head.valid = (count != '0);
  assign head.entry = mem[rd_ptr];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_entry;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/z85_back.sv =====
`default_nettype none
`include "z85_codec_with_position_rotation_defines.svh"

module z85_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [6:0]         step,
  input  wire z85_pkg::z85_head_t head,
  output logic                    pop,
  z85_out_if.source               result
);
  import z85_pkg::*;

  // digit to alphabet symbol
  function automatic logic [7:0] digit_char(input logic [DIG_W-1:0] d);
    logic [7:0] c;
    c = "#";
    if (d < 7'd10) c = 8'd48 + 8'(d);
    else if (d < 7'd36) c = 8'd87 + 8'(d);
    else if (d < 7'd62) c = 8'd29 + 8'(d);
    else begin
      unique case (d)
        7'd62: c = ".";
        7'd63: c = "-";
        7'd64: c = ":";
        7'd65: c = "+";
        7'd66: c = "=";
        7'd67: c = "^";
        7'd68: c = "!";
        7'd69: c = "/";
        7'd70: c = "*";
        7'd71: c = "?";
        7'd72: c = "&";
        7'd73: c = "<";
        7'd74: c = ">";
        7'd75: c = "(";
        7'd76: c = ")";
        7'd77: c = "[";
        7'd78: c = "]";
        7'd79: c = "{";
        7'd80: c = "}";
        7'd81: c = "@";
        7'd82: c = "%";
        7'd83: c = "$";
        default: c = "#";
      endcase
    end
    return c;
  endfunction

  logic [DIG_W-1:0] off;
  logic [2:0]       gcnt;
  logic [31:0]      acc;
  logic             gerr;
  logic [2:0]       cidx;

  logic             ovalid;
  logic [7:0]       ochar;
  logic [31:0]      oword;
  logic             olast;
  logic             obad;

  logic             clr;
  logic [DIG_W-1:0] off_cur;
  logic [7:0]       off_sum;
  logic [DIG_W-1:0] off_adv;
  logic [DIG_W-1:0] dcur;
  logic [7:0]       enc_diff;
  logic [DIG_W-1:0] sym;
  logic [7:0]       dec_sum;
  logic [DIG_W-1:0] dec_dig;
  logic [31:0]      acc_base;
  logic [31:0]      acc_new;
  logic             err_base;
  logic [2:0]       cnt_base;
  logic             fifth;
  logic             can_load;
  logic             fire_enc;
  logic             fire_dec;
  logic             enc_end;

  assign can_load = !ovalid || result.ready;

  // stream restart applies before the first character of an item
  assign clr     = head.entry.sos && (cidx == '0);
  assign off_cur = clr ? '0 : off;
  assign off_sum = {1'b0, off_cur} + {1'b0, step};
  assign off_adv = (off_sum >= {1'b0, SYMBOLS}) ? DIG_W'(off_sum - {1'b0, SYMBOLS})
                                                : off_sum[DIG_W-1:0];

  // encode: rotate current digit down
  assign dcur     = head.entry.dig[cidx];
  assign enc_diff = {1'b0, dcur} - {1'b0, off_cur};
  assign sym      = (dcur < off_cur) ? DIG_W'(enc_diff + {1'b0, SYMBOLS})
                                     : enc_diff[DIG_W-1:0];

  // decode: rotate character digit up, bad characters give digit zero
  assign dec_sum  = {1'b0, head.entry.cdig} + {1'b0, off_cur};
  assign dec_dig  = head.entry.cbad ? '0
                  : (dec_sum >= {1'b0, SYMBOLS}) ? DIG_W'(dec_sum - {1'b0, SYMBOLS})
                                                 : dec_sum[DIG_W-1:0];
  assign acc_base = clr ? '0 : acc;
  assign err_base = clr ? 1'b0 : gerr;
  assign cnt_base = clr ? '0 : gcnt;
  assign acc_new  = 32'(acc_base * 32'd85) + 32'(dec_dig);
  assign fifth    = (cnt_base == 3'(LAST_DIGIT));

  assign fire_enc = head.valid && !head.entry.dec && can_load;
  assign fire_dec = head.valid && head.entry.dec && (!fifth || can_load);
  assign enc_end  = (cidx == 3'(LAST_DIGIT));
  assign pop      = fire_dec || (fire_enc && enc_end);

  // stream state, character index and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      off    <= '0;
      gcnt   <= '0;
      acc    <= '0;
      gerr   <= 1'b0;
      cidx   <= '0;
      ovalid <= 1'b0;
    end else begin
      ovalid <= fire_enc || (fire_dec && fifth) || (ovalid && !result.ready);
      if (fire_enc) begin
        off    <= off_adv;
        cidx   <= enc_end ? '0 : cidx + 1'b1;
        ochar  <= digit_char(sym);
        oword  <= '0;
        olast  <= enc_end;
        obad   <= 1'b0;
        if (clr) begin
          gcnt <= '0;
          acc  <= '0;
          gerr <= 1'b0;
        end
      end else if (fire_dec) begin
        off <= off_adv;
        if (fifth) begin
          gcnt   <= '0;
          acc    <= '0;
          gerr   <= 1'b0;
          ochar  <= '0;
          oword  <= acc_new;
          olast  <= 1'b1;
          obad   <= err_base || head.entry.cbad;
        end else begin
          gcnt <= cnt_base + 1'b1;
          acc  <= acc_new;
          gerr <= err_base || head.entry.cbad;
        end
      end
    end
  end

  assign result.valid    = ovalid;
  assign result.out_char = ochar;
  assign result.out_word = oword;
  assign result.last     = olast;
  assign result.bad_char = obad;

  `Z85_ASSERT_NOW(a_off_range, 1'b1, off < SYMBOLS, "position offset left 0..84")
  `Z85_ASSERT_NOW(a_cnt_range, 1'b1, gcnt <= 3'(LAST_DIGIT), "group count past four")
  `Z85_ASSERT_NOW(a_enc_hold, cidx != '0, head.valid && !head.entry.dec,
                  "encode word lost mid emission")
  `Z85_ASSERT_NEXT(a_dec_done, fire_dec && fifth, ovalid && olast && gcnt == '0,
                   "decoded word not loaded")

endmodule

`default_nettype wire

// ===== rtl/core/z85_codec_with_position_rotation.sv =====
`default_nettype none
// Z85 codec with a per-character rotation of (N * position) mod 85.
// Channels: item (start_of_stream, data_word, in_char) and result (out_char,
// out_word, last, bad_char), both valid/ready; a transfer happens when both
// are high. Configuration is a plain write port: reg_index 0 is the rotation
// step, 1 is decode_mode; write only while the block is idle.
// Encode: each word gives five characters, most significant digit first,
// last set on the fifth. Decode: one character per item, a word comes out
// after every fifth character with bad_char for a group that held an invalid
// symbol.
// Path: the first result of an item passes four divide stages, the first
// loaded at the transfer, then the queue and the output register.
// Throughput: one character per cycle through the output register while the
// receiver is ready; the input keeps flowing while results wait, until the
// divide pipeline and the queue fill up.
// Reset clears the stream position, the partial decode group, the queue and
// both config registers. A stalled receiver holds the current result and
// back-pressures the queue and then the input.
module z85_codec_with_position_rotation #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       wr_en,
  input  wire logic       reg_index,
  input  wire logic [6:0] wr_data,
  z85_in_if.sink          item,
  z85_out_if.source       result
);
  import z85_pkg::*;

  localparam logic REG_ROTATION_STEP = 1'b0;
  localparam logic REG_DECODE_MODE   = 1'b1;

  logic [6:0] rotation_step;
  logic       decode_mode;
  logic       q_push;
  logic       q_full;
  logic       q_pop;
  z85_entry_t q_entry;
  z85_head_t  q_head;

  // config registers, step kept reduced modulo 85
  always_ff @(posedge clk) begin
    if (rst) begin
      rotation_step <= '0;
      decode_mode   <= 1'b0;
    end else if (wr_en) begin
      unique case (reg_index)
        REG_ROTATION_STEP: rotation_step <= (wr_data >= SYMBOLS) ? wr_data - SYMBOLS
                                                                 : wr_data;
        REG_DECODE_MODE:   decode_mode <= wr_data[0];
        default: ;
      endcase
    end
  end

  z85_front u_front (
    .clk         (clk),
    .rst         (rst),
    .decode_mode (decode_mode),
    .item        (item),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_entry     (q_entry)
  );

  z85_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .pop        (q_pop),
    .head       (q_head)
  );

  z85_back u_back (
    .clk    (clk),
    .rst    (rst),
    .step   (rotation_step),
    .head   (q_head),
    .pop    (q_pop),
    .result (result)
  );

endmodule

`default_nettype wire

// ===== bench/tb_z85_codec_with_position_rotation.sv =====
`timescale 1ns / 1ps

module tb_z85_codec_with_position_rotation;

  localparam int Z85_BASE = 85;
  localparam string Z85_ALPHABET =
    "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ.-:+=^!/*?&<>()[]{}@%$#";

  localparam logic REG_STEP    = 1'b0;
  localparam logic REG_MODE    = 1'b1;
  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam int SETTLE_CYCLES  = 16;
  localparam int RX_HOLD_CYCLES = 80;
  localparam int RX_STEADY_FROM = 1200;
  localparam int RX_STEADY_TO   = 1800;
  localparam int CYCLE_LIMIT    = 200000;
  localparam int MAX_REPORTS    = 10;

  typedef struct packed {
    logic [7:0]  chr;
    logic [31:0] word;
    logic        last;
    logic        bad;
  } z85_result_t;

  // codec predictor with its own copy of state and registers
  class z85_scoreboard;
    logic [6:0]  rot_step;
    logic        dec_mode;
    logic [6:0]  pos;
    logic [2:0]  grp_cnt;
    logic [31:0] grp_acc;
    logic        grp_err;
    z85_result_t expected_q[$];
    int mismatches;
    int n_items;
    int n_checked;
    int n_words;
    int n_groups;
    int n_bad_groups;

    function new();
      rot_step = '0;
      dec_mode = MODE_ENCODE;
      clear_stream();
      mismatches = 0;
      n_items = 0;
      n_checked = 0;
      n_words = 0;
      n_groups = 0;
      n_bad_groups = 0;
    endfunction

    function void clear_stream();
      pos = '0;
      grp_cnt = '0;
      grp_acc = '0;
      grp_err = 1'b0;
    endfunction

    function void set_reg(input logic idx, input logic [6:0] val);
      if (idx == REG_STEP) rot_step = val;
      else dec_mode = val[0];
    endfunction

    function void advance();
      pos = 7'((int'(pos) + int'(rot_step) % Z85_BASE) % Z85_BASE);
    endfunction

    // digit of a symbol, -1 when it is not in the alphabet
    function int symbol_value(input logic [7:0] chr);
      for (int k = 0; k < Z85_BASE; k++)
        if (8'(Z85_ALPHABET[k]) == chr) return k;
      return -1;
    endfunction

    function void note_item(input logic sos, input logic [31:0] word, input logic [7:0] chr);
      int digs[5];
      int sym;
      int d;
      int digit;
      logic [31:0] w;
      z85_result_t exp_r;
      n_items++;
      if (sos) clear_stream();
      if (dec_mode == MODE_ENCODE) begin
        // five base-85 digits, most significant first, each rotated down
        w = word;
        for (int k = 4; k >= 0; k--) begin
          digs[k] = int'(w % 32'd85);
          w = w / 32'd85;
        end
        for (int k = 0; k < 5; k++) begin
          sym = (digs[k] + Z85_BASE - int'(pos)) % Z85_BASE;
          exp_r.chr = 8'(Z85_ALPHABET[sym]);
          exp_r.word = '0;
          exp_r.last = (k == 4);
          exp_r.bad = 1'b0;
          expected_q.push_back(exp_r);
          advance();
        end
        n_words++;
      end else begin
        // rotate the digit up, invalid symbols count as zero
        d = symbol_value(chr);
        if (d < 0) begin
          grp_err = 1'b1;
          digit = 0;
        end else begin
          digit = (d + int'(pos)) % Z85_BASE;
        end
        advance();
        grp_acc = grp_acc * 32'd85 + 32'(digit);
        grp_cnt = grp_cnt + 3'd1;
        if (grp_cnt == 3'd5) begin
          exp_r.chr = '0;
          exp_r.word = grp_acc;
          exp_r.last = 1'b1;
          exp_r.bad = grp_err;
          expected_q.push_back(exp_r);
          n_groups++;
          if (grp_err) n_bad_groups++;
          grp_cnt = '0;
          grp_acc = '0;
          grp_err = 1'b0;
        end
      end
    endfunction

    function void check_result(input z85_result_t got);
      z85_result_t exp_r;
      n_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: char=%h word=%h last=%b bad=%b",
                   got.chr, got.word, got.last, got.bad);
        return;
      end
      exp_r = expected_q.pop_front();
      if (got.chr !== exp_r.chr || got.word !== exp_r.word ||
          got.last !== exp_r.last || got.bad !== exp_r.bad) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch on result %0d: expected char=%h word=%h last=%b bad=%b, got char=%h word=%h last=%b bad=%b",
                   n_checked, exp_r.chr, exp_r.word, exp_r.last, exp_r.bad,
                   got.chr, got.word, got.last, got.bad);
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       wr_en;
  logic       reg_index;
  logic [6:0] wr_data;
  logic       hold_req;
  logic       steady_tx = 1'b0;
  int         cycle_count = 0;

  z85_in_if  item_ch ();
  z85_out_if result_ch ();

  z85_scoreboard sb = new();

  z85_codec_with_position_rotation dut (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .reg_index (reg_index),
    .wr_data   (wr_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  always #5 clk = ~clk;

  // run length guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count, sb.pending());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stalls, one long hold-off, one window without stalls
  initial begin : receiver
    logic hold_seen;
    int   hold_left;
    hold_seen = 1'b0;
    hold_left = 0;
    result_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_seen) hold_left = RX_HOLD_CYCLES;
      hold_seen = hold_req;
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else if (cycle_count >= RX_STEADY_FROM && cycle_count < RX_STEADY_TO) begin
        result_ch.ready <= 1'b1;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= 8);
      end
    end
  end

  // result transfers go to the scoreboard
  always @(posedge clk) begin : result_monitor
    z85_result_t got;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.chr = result_ch.out_char;
      got.word = result_ch.out_word;
      got.last = result_ch.last;
      got.bad = result_ch.bad_char;
      sb.check_result(got);
    end
  end

  // write both registers, block must be idle
  task automatic configure(input logic [6:0] step, input logic mode);
    wr_en <= 1'b1;
    reg_index <= REG_STEP;
    wr_data <= step;
    @(posedge clk);
    sb.set_reg(REG_STEP, step);
    reg_index <= REG_MODE;
    wr_data <= {6'd0, mode};
    @(posedge clk);
    sb.set_reg(REG_MODE, {6'd0, mode});
    wr_en <= 1'b0;
  endtask

  // offer one item and wait for its transfer
  task automatic send_item(input logic sos, input logic [31:0] word, input logic [7:0] chr);
    int gap;
    gap = 0;
    if (!steady_tx && $urandom_range(99) < 8) gap = $urandom_range(4, 1);
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.start_of_stream <= sos;
    item_ch.data_word <= word;
    item_ch.in_char <= chr;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    sb.note_item(sos, word, chr);
  endtask

  // stop offering, let every result arrive, then let the pipeline settle
  task automatic drain();
    item_ch.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // random items in one setting; mostly valid symbols in decode mode
  task automatic run_random(input int count, input int hold_at, input int pause_at);
    logic        sos;
    logic [31:0] word;
    logic [7:0]  chr;
    int          pick;
    for (int n = 0; n < count; n++) begin
      if (n == hold_at) hold_req <= 1'b1;
      if (n == hold_at + 12) hold_req <= 1'b0;
      if (n == pause_at) drain();
      sos = ($urandom_range(99) < 4);
      pick = $urandom_range(99);
      word = $urandom;
      if (sb.dec_mode == MODE_ENCODE) begin
        if (pick < 8) word = 32'h0000_0000;
        else if (pick < 16) word = 32'hFFFF_FFFF;
        chr = 8'($urandom_range(255, 0));
      end else begin
        if (pick < 10) chr = 8'($urandom_range(255, 0));
        else chr = 8'(Z85_ALPHABET[$urandom_range(Z85_BASE - 1, 0)]);
      end
      send_item(sos, word, chr);
    end
  endtask

  initial begin
    rst <= 1'b1;
    wr_en <= 1'b0;
    reg_index <= REG_STEP;
    wr_data <= '0;
    hold_req <= 1'b0;
    item_ch.valid <= 1'b0;
    item_ch.start_of_stream <= 1'b0;
    item_ch.data_word <= '0;
    item_ch.in_char <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // encode extremes without rotation
    configure(7'd0, MODE_ENCODE);
    send_item(1'b1, 32'h0000_0000, 8'h00);
    send_item(1'b0, 32'hFFFF_FFFF, 8'hFF);
    send_item(1'b0, 32'h864F_D26F, 8'h00);
    drain();

    // largest in-range step
    configure(7'd84, MODE_ENCODE);
    send_item(1'b1, 32'h1234_5678, 8'h00);
    send_item(1'b0, 32'hFFFF_FFFF, 8'h00);
    drain();

    // step above 84 wraps; a group of five '#' symbols overflows 32 bits
    configure(7'd127, MODE_DECODE);
    send_item(1'b1, 32'h0, "#");
    repeat (4) send_item(1'b0, 32'h0, "#");
    // partial group, then restart mid-group with symbols outside the alphabet
    send_item(1'b0, 32'h0, "0");
    send_item(1'b0, 32'h0, "1");
    send_item(1'b1, 32'hFFFF_FFFF, 8'h00);
    send_item(1'b0, 32'h0, "a");
    send_item(1'b0, 32'h0, 8'hFF);
    send_item(1'b0, 32'h0, 8'h22); // double quote is not a symbol
    send_item(1'b0, 32'h0, "Z");
    // mode change in the middle of a decode group
    send_item(1'b0, 32'h0, "k");
    send_item(1'b0, 32'h0, "?");
    drain();
    configure(7'd85, MODE_ENCODE);
    send_item(1'b0, 32'hDEAD_BEEF, 8'h00);
    drain();
    configure(7'd85, MODE_DECODE);
    send_item(1'b0, 32'h0, "(");
    send_item(1'b0, 32'h0, "}");
    send_item(1'b0, 32'h0, "0");
    drain();

    // random phases over several settings; first one has a long receiver hold
    configure(7'($urandom_range(84, 1)), MODE_ENCODE);
    steady_tx = 1'b1;
    run_random(80, 20, -1);
    steady_tx = 1'b0;
    drain();
    configure(7'd0, MODE_DECODE);
    run_random(60, -100, -1);
    drain();
    configure(7'd84, MODE_DECODE);
    run_random(60, -100, 30);
    drain();
    configure(7'd127, MODE_ENCODE);
    run_random(50, -100, 25);
    drain();
    configure(7'($urandom_range(127, 0)), MODE_DECODE);
    run_random(80, -100, -1);
    drain();
    configure(7'($urandom_range(127, 0)), MODE_ENCODE);
    run_random(55, -100, -1);
    drain();

    $display("covered %0d items: %0d words encoded, %0d groups decoded (%0d with bad symbols)",
             sb.n_items, sb.n_words, sb.n_groups, sb.n_bad_groups);
    $display("%0d results checked, %0d mismatches, %0d results never seen",
             sb.n_checked, sb.mismatches, sb.pending());
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
